// ----- design/jsvs_pkg.sv -----
// Shared types and constants for the joystick shaping and vector slew block.
// Item structs, configuration register set and register index codes.
// No dependencies.
package jsvs_pkg;

  localparam int AXIS_WIDTH  = 16;
  localparam int CMD_WIDTH   = 16;
  localparam int REG_WIDTH   = 15;
  localparam int IDX_WIDTH   = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [AXIS_WIDTH-1:0] move_axis;
    logic signed [AXIS_WIDTH-1:0] rotate_axis;
  } in_item_t;

  typedef struct packed {
    logic signed [CMD_WIDTH-1:0] drive_cmd;
    logic signed [CMD_WIDTH-1:0] turn_cmd;
    logic                        was_limited;
  } out_item_t;

  typedef struct packed {
    logic signed [CMD_WIDTH-1:0] drive_tgt;
    logic signed [CMD_WIDTH-1:0] turn_tgt;
  } tgt_item_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0] dead_zone;
    logic [REG_WIDTH-1:0] friction_offset;
    logic [REG_WIDTH-1:0] speed_gain;
    logic [REG_WIDTH-1:0] max_step;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    tgt_item_t data;
  } push_t;

  typedef struct packed {
    logic      empty;
    tgt_item_t data;
  } head_t;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_DEAD_ZONE       = 4'd0,
    REG_FRICTION_OFFSET = 4'd1,
    REG_SPEED_GAIN      = 4'd2,
    REG_MAX_STEP        = 4'd3
  } reg_idx_t;

endpackage

// ----- design/jsvs_front.sv -----
// Front end: takes an axis pair, applies dead zone friction, negation and gain.
// One shared multiplier, axes in turn; pushes the target pair into the queue.
// Depends on jsvs_pkg.
module jsvs_front
  import jsvs_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output push_t    push,
  input  logic     q_full
);

  localparam int SHW   = AXIS_WIDTH + 2;
  localparam int MAGW  = SHW - 1;
  localparam int PRODW = MAGW + REG_WIDTH;
  localparam int CLW   = PRODW + 2;
  localparam logic [CLW-1:0] CMAX = (CLW'(1) << (CMD_WIDTH - 1)) - CLW'(1);
  localparam logic [PRODW:0] RND  = (PRODW + 1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_RND, F_PUSH} fstate_t;

  fstate_t                     state_r;
  logic                        sel_r;
  in_item_t                    axes_r;
  logic [PRODW-1:0]            prod_r;
  logic                        neg_r;
  logic signed [CMD_WIDTH-1:0] drive_r;
  logic signed [CMD_WIDTH-1:0] turn_r;

  logic signed [SHW-1:0] ax;
  logic signed [SHW-1:0] dz_s;
  logic signed [SHW-1:0] fo_s;
  logic signed [SHW-1:0] shaped;
  logic [MAGW-1:0]       mag;
  logic                  neg_nxt;
  logic [PRODW:0]        rnd_sum;
  logic [PRODW:0]        mag_q;
  logic [PRODW:0]        neg_q;
  logic [CMD_WIDTH-1:0]  tgt_nxt;

  always_comb begin
    ax   = sel_r ? SHW'(axes_r.rotate_axis) : SHW'(axes_r.move_axis);
    dz_s = $signed({3'b000, cfg.dead_zone});
    fo_s = $signed({3'b000, cfg.friction_offset});
    if (ax > dz_s) begin
      shaped = ax + fo_s;
    end else if (ax < -dz_s) begin
      shaped = ax - fo_s;
    end else begin
      shaped = ax;
    end
    // after negation the sign flips
    neg_nxt = shaped > 0;
    mag     = shaped[SHW-1] ? MAGW'(-shaped) : MAGW'(shaped);
  end

  always_comb begin
    rnd_sum = {1'b0, prod_r} + RND;
    mag_q   = rnd_sum >> FRAC_BITS;
    neg_q   = '0 - mag_q;
    if (!neg_r) begin
      tgt_nxt = ({1'b0, mag_q} > CMAX) ? CMAX[CMD_WIDTH-1:0] : mag_q[CMD_WIDTH-1:0];
    end else begin
      tgt_nxt = ({1'b0, mag_q} > CMAX + CLW'(1)) ? ~CMAX[CMD_WIDTH-1:0]
                                                 : neg_q[CMD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      sel_r   <= 1'b0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            axes_r  <= in_data;
            sel_r   <= 1'b0;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          prod_r  <= PRODW'(mag) * PRODW'(cfg.speed_gain);
          neg_r   <= neg_nxt;
          state_r <= F_RND;
        end
        F_RND: begin
          if (!sel_r) begin
            drive_r <= $signed(tgt_nxt);
            sel_r   <= 1'b1;
            state_r <= F_MUL;
          end else begin
            turn_r  <= $signed(tgt_nxt);
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign in_stall            = state_r != F_IDLE;
  assign push.valid          = state_r == F_PUSH;
  assign push.data.drive_tgt = drive_r;
  assign push.data.turn_tgt  = turn_r;

endmodule

// ----- design/jsvs_queue.sv -----
// Short queue of target pairs between the front end and the slew back end.
// Depends on jsvs_pkg.
module jsvs_queue
  import jsvs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  full,
  input  logic  pop,
  output head_t head
);

  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  tgt_item_t       mem_r [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr_r;
  logic [PTRW-1:0] rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full       = cnt_r == CNTW'(QUEUE_DEPTH);
  assign head.empty = cnt_r == '0;
  assign head.data  = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && !head.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTRW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTRW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNTW'(1);
        2'b01:   cnt_r <= cnt_r - CNTW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/jsvs_back.sv -----
// Back end: step vector, length test, iterative square root and divide,
// scaled command update and the registered result.
// Depends on jsvs_pkg.
module jsvs_back
  import jsvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  head_t                head,
  output logic                 pop,
  input  logic [REG_WIDTH-1:0] max_step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int CW    = CMD_WIDTH;
  localparam int RW    = (CW < 30) ? CW : 30;
  localparam int MA    = (RW > REG_WIDTH) ? RW : REG_WIDTH;
  localparam int PW    = 2 * MA;
  localparam int SW    = 2 * RW + 1;
  localparam int CPW   = (SW > 2 * REG_WIDTH) ? SW : 2 * REG_WIDTH;
  localparam int N     = (SW + 1) / 2;
  localparam int RTW   = 2 * N;
  localparam int LW    = N;
  localparam int NUMW  = RW + REG_WIDTH;
  localparam int CNTW  = $clog2(NUMW);
  localparam logic signed [CW+1:0] CMAX_S = (CW + 2)'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [CW+1:0] CMIN_S = -CMAX_S - (CW + 2)'(1);

  typedef enum logic [3:0] {
    B_IDLE, B_SHIFT, B_SQX, B_SQY, B_SQM, B_CMP, B_SQRT, B_MULS, B_DIV, B_ADD, B_OUT
  } bstate_t;

  bstate_t                  state_r;
  logic signed [CW-1:0]     prev_x_r;
  logic signed [CW-1:0]     prev_y_r;
  logic signed [CW-1:0]     tx_r;
  logic signed [CW-1:0]     ty_r;
  logic signed [CW-1:0]     cmd_x_r;
  logic [CW-1:0]            mx_r;
  logic [CW-1:0]            my_r;
  logic                     nx_r;
  logic                     ny_r;
  logic                     sel_r;
  logic [2*RW-1:0]          sqx_r;
  logic [2*RW-1:0]          sqy_r;
  logic [2*REG_WIDTH-1:0]   mm_r;
  logic [RTW-1:0]           rv_r;
  logic [RTW-1:0]           res_r;
  logic [RTW-1:0]           bit_r;
  logic [NUMW-1:0]          num_r;
  logic [LW-1:0]            rem_r;
  logic [CNTW-1:0]          cnt_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic signed [CW:0]       dx;
  logic signed [CW:0]       dy;
  logic [CW:0]              ax;
  logic [CW:0]              ay;
  logic                     huge;
  logic [MA-1:0]            mul_a;
  logic [MA-1:0]            mul_b;
  logic [PW-1:0]            mul_p;
  logic [SW-1:0]            sum;
  logic                     limited;
  logic [RTW:0]             trial_r;
  logic [LW-1:0]            len;
  logic [LW:0]              trial_d;
  logic                     ge;
  logic [LW:0]              diff_d;
  logic signed [CW+1:0]     base;
  logic signed [CW+1:0]     stepv;
  logic signed [CW+1:0]     acc;
  logic signed [CW-1:0]     cmd_nxt;

  always_comb begin
    dx = {head.data.drive_tgt[CW-1], head.data.drive_tgt} - {prev_x_r[CW-1], prev_x_r};
    dy = {head.data.turn_tgt[CW-1], head.data.turn_tgt} - {prev_y_r[CW-1], prev_y_r};
    ax = dx[CW] ? (CW + 1)'(-dx) : (CW + 1)'(dx);
    ay = dy[CW] ? (CW + 1)'(-dy) : (CW + 1)'(dy);
    huge = ((mx_r >> 30) != '0) || ((my_r >> 30) != '0);
  end

  always_comb begin
    unique case (state_r)
      B_SQX:   begin mul_a = MA'(mx_r[RW-1:0]); mul_b = MA'(mx_r[RW-1:0]); end
      B_SQY:   begin mul_a = MA'(my_r[RW-1:0]); mul_b = MA'(my_r[RW-1:0]); end
      B_SQM:   begin mul_a = MA'(max_step);     mul_b = MA'(max_step);     end
      B_MULS:  begin
        mul_a = sel_r ? MA'(my_r[RW-1:0]) : MA'(mx_r[RW-1:0]);
        mul_b = MA'(max_step);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    sum     = SW'(sqx_r) + SW'(sqy_r);
    limited = CPW'(sum) > CPW'(mm_r);
    trial_r = {1'b0, res_r} + {1'b0, bit_r};
    len     = res_r[LW-1:0];
    trial_d = {rem_r, num_r[NUMW-1]};
    ge      = trial_d >= {1'b0, len};
    diff_d  = trial_d - {1'b0, len};
  end

  always_comb begin
    base  = sel_r ? (CW + 2)'(prev_y_r) : (CW + 2)'(prev_x_r);
    stepv = $signed((CW + 2)'(num_r[RW-1:0]));
    acc   = (sel_r ? ny_r : nx_r) ? base - stepv : base + stepv;
    if (acc > CMAX_S) begin
      cmd_nxt = CMAX_S[CW-1:0];
    end else if (acc < CMIN_S) begin
      cmd_nxt = CMIN_S[CW-1:0];
    end else begin
      cmd_nxt = acc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!head.empty) begin
            tx_r    <= head.data.drive_tgt;
            ty_r    <= head.data.turn_tgt;
            nx_r    <= dx[CW];
            ny_r    <= dy[CW];
            mx_r    <= ax[CW-1:0];
            my_r    <= ay[CW-1:0];
            state_r <= B_SHIFT;
          end
        end
        B_SHIFT: begin
          if (huge) begin
            mx_r <= mx_r >> 1;
            my_r <= my_r >> 1;
          end else begin
            state_r <= B_SQX;
          end
        end
        B_SQX: begin
          sqx_r   <= mul_p[2*RW-1:0];
          state_r <= B_SQY;
        end
        B_SQY: begin
          sqy_r   <= mul_p[2*RW-1:0];
          state_r <= B_SQM;
        end
        B_SQM: begin
          mm_r    <= mul_p[2*REG_WIDTH-1:0];
          state_r <= B_CMP;
        end
        B_CMP: begin
          if (limited) begin
            rv_r    <= RTW'(sum);
            res_r   <= '0;
            bit_r   <= RTW'(1) << (RTW - 2);
            state_r <= B_SQRT;
          end else begin
            out_r.drive_cmd   <= tx_r;
            out_r.turn_cmd    <= ty_r;
            out_r.was_limited <= 1'b0;
            prev_x_r          <= tx_r;
            prev_y_r          <= ty_r;
            out_valid_r       <= 1'b1;
            state_r           <= B_OUT;
          end
        end
        B_SQRT: begin
          if ({1'b0, rv_r} >= trial_r) begin
            rv_r  <= rv_r - trial_r[RTW-1:0];
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            sel_r   <= 1'b0;
            state_r <= B_MULS;
          end
        end
        B_MULS: begin
          num_r   <= mul_p[NUMW-1:0];
          rem_r   <= '0;
          cnt_r   <= CNTW'(NUMW - 1);
          state_r <= B_DIV;
        end
        B_DIV: begin
          rem_r <= ge ? diff_d[LW-1:0] : trial_d[LW-1:0];
          num_r <= {num_r[NUMW-2:0], ge};
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == '0) begin
            state_r <= B_ADD;
          end
        end
        B_ADD: begin
          if (!sel_r) begin
            cmd_x_r <= cmd_nxt;
            sel_r   <= 1'b1;
            state_r <= B_MULS;
          end else begin
            out_r.drive_cmd   <= cmd_x_r;
            out_r.turn_cmd    <= cmd_nxt;
            out_r.was_limited <= 1'b1;
            prev_x_r          <= cmd_x_r;
            prev_y_r          <= cmd_nxt;
            out_valid_r       <= 1'b1;
            state_r           <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign pop       = (state_r == B_IDLE) && !head.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/joystick_shaping_vector_slew.sv -----
// Top level of the joystick shaping and vector slew limiter.
// Holds the configuration registers; instantiates jsvs_front, jsvs_queue, jsvs_back.
// Depends on jsvs_pkg.
//
//   port group | direction | handshake        | payload
//   in_        | in        | in_valid/in_stall | in_item_t  (move_axis, rotate_axis)
//   out_       | out       | out_valid/out_stall | out_item_t (drive_cmd, turn_cmd, was_limited)
//   cfg_       | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Front end: accepts an axis pair only when idle, makes two multiply/round passes
// on one multiplier, then pushes. Back end: when the step is within max_step the
// targets pass straight through; otherwise the step is scaled with an iterative square
// root and a bit-serial divider, one divide per axis. A two-entry queue lets the
// front take new transfers while a result waits on out_stall. Reset is
// synchronous and clears the queue, the previous commands and the registers to defaults.
module joystick_shaping_vector_slew
  import jsvs_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0] cfg_data
);

  localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] DZ_RST  = (ONE_Q + 64'd5) / 64'd10;
  localparam logic [63:0] FO_RST  = (64'd2 * ONE_Q + 64'd5) / 64'd10;
  localparam logic [63:0] MS_RST  = (ONE_Q + 64'd20) / 64'd40;

  cfg_t  cfg_r;
  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone       <= DZ_RST[REG_WIDTH-1:0];
      cfg_r.friction_offset <= FO_RST[REG_WIDTH-1:0];
      cfg_r.speed_gain      <= ONE_Q[REG_WIDTH-1:0];
      cfg_r.max_step        <= MS_RST[REG_WIDTH-1:0];
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEAD_ZONE:       cfg_r.dead_zone       <= cfg_data;
        REG_FRICTION_OFFSET: cfg_r.friction_offset <= cfg_data;
        REG_SPEED_GAIN:      cfg_r.speed_gain      <= cfg_data;
        REG_MAX_STEP:        cfg_r.max_step        <= cfg_data;
        default:             cfg_r                 <= cfg_r;
      endcase
    end
  end

  jsvs_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .push     (push),
    .q_full   (q_full)
  );

  jsvs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  jsvs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .max_step  (cfg_r.max_step),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb_joystick_shaping_vector_slew.sv -----
// Testbench for joystick_shaping_vector_slew: directed and random axis pairs,
// register sweeps and receiver hold-off, each result checked against a local predictor.
// Depends on jsvs_pkg and the joystick_shaping_vector_slew RTL.
`timescale 1ns / 100ps

module tb_joystick_shaping_vector_slew;
  import jsvs_pkg::*;

  localparam int  FRAC       = 14;
  localparam int  ONE_Q      = 1 << FRAC;
  localparam int  CMD_HI     = 32767;
  localparam int  CMD_LO     = -32768;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  END_WAIT   = 120;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_WIDTH-1:0] cfg_index;
  logic [REG_WIDTH-1:0] cfg_data;

  joystick_shaping_vector_slew uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of registers and previous commands
  logic [REG_WIDTH-1:0] dz_r;
  logic [REG_WIDTH-1:0] fo_r;
  logic [REG_WIDTH-1:0] gain_r;
  logic [REG_WIDTH-1:0] step_r;
  longint               prev_drive_q;
  longint               prev_turn_q;

  out_item_t pending_cmds[$];

  int  errors;
  int  n_sent;
  int  n_recv;
  int  n_limited;
  int  n_cfg;
  int  n_in_stalls;
  int  cycle_cnt;
  bit  idle_on;
  int  stall_left;
  int  hold_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_cmds.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint clamp_cmd16(longint v);
    if (v > CMD_HI) return CMD_HI;
    if (v < CMD_LO) return CMD_LO;
    return v;
  endfunction

  function automatic longint shape_axis_target(logic signed [AXIS_WIDTH-1:0] ax);
    longint a;
    longint mag;
    bit     neg;
    a = ax;
    if (a > longint'(dz_r)) a = a + longint'(fo_r);
    else if (a < -longint'(dz_r)) a = a - longint'(fo_r);
    a = -a;
    neg = (a < 0);
    mag = (neg ? -a : a) * longint'(gain_r);
    mag = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
    return clamp_cmd16(neg ? -mag : mag);
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    longint t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (longint'(1) << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic out_item_t next_commands(in_item_t it);
    out_item_t res;
    longint    tx, ty, dx, dy, mx, my, m, sum, len, sx, sy, cx, cy;
    bit        nx, ny, lim;
    tx = shape_axis_target(it.move_axis);
    ty = shape_axis_target(it.rotate_axis);
    dx = tx - prev_drive_q;
    dy = ty - prev_turn_q;
    nx = (dx < 0);
    ny = (dy < 0);
    mx = nx ? -dx : dx;
    my = ny ? -dy : dy;
    while (mx >= (longint'(1) << 30) || my >= (longint'(1) << 30)) begin
      mx = mx >> 1;
      my = my >> 1;
    end
    m   = longint'(step_r);
    sum = mx * mx + my * my;
    lim = (sum > m * m);
    if (lim) begin
      len = root_floor(sum);
      sx  = (mx * m) / len;
      sy  = (my * m) / len;
      cx  = clamp_cmd16(prev_drive_q + (nx ? -sx : sx));
      cy  = clamp_cmd16(prev_turn_q + (ny ? -sy : sy));
    end else begin
      cx = tx;
      cy = ty;
    end
    prev_drive_q    = cx;
    prev_turn_q     = cy;
    res.drive_cmd   = cx[CMD_WIDTH-1:0];
    res.turn_cmd    = cy[CMD_WIDTH-1:0];
    res.was_limited = lim;
    return res;
  endfunction

  // result checker and receiver stall draw
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_recv++;
      if (out_data.was_limited) n_limited++;
      if (pending_cmds.size() == 0) begin
        $error("unexpected result drive_cmd %0d turn_cmd %0d", out_data.drive_cmd,
               out_data.turn_cmd);
        errors++;
      end else begin
        automatic out_item_t exp = pending_cmds.pop_front();
        if (out_data.drive_cmd !== exp.drive_cmd) begin
          $error("drive_cmd expected %0d actual %0d", exp.drive_cmd, out_data.drive_cmd);
          errors++;
        end
        if (out_data.turn_cmd !== exp.turn_cmd) begin
          $error("turn_cmd expected %0d actual %0d", exp.turn_cmd, out_data.turn_cmd);
          errors++;
        end
        if (out_data.was_limited !== exp.was_limited) begin
          $error("was_limited expected %0d actual %0d", exp.was_limited,
                 out_data.was_limited);
          errors++;
        end
      end
      stall_left = idle_on ? $urandom_range(0, 7) : 0;
    end
  end

  // receiver: long hold-off first, then per-transfer stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_axes(input logic signed [AXIS_WIDTH-1:0] mv,
                           input logic signed [AXIS_WIDTH-1:0] rt);
    in_item_t it;
    int       gap;
    it.move_axis   = mv;
    it.rotate_axis = rt;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk);
      if (in_stall) n_in_stalls++;
    end while (in_stall);
    pending_cmds.push_back(next_commands(it));
    n_sent++;
  endtask

  task automatic cfg_write(input logic [IDX_WIDTH-1:0] idx,
                           input logic [REG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEAD_ZONE:       dz_r   = val;
      REG_FRICTION_OFFSET: fo_r   = val;
      REG_SPEED_GAIN:      gain_r = val;
      REG_MAX_STEP:        step_r = val;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_default_shaping();
    idle_on = 1'b1;
    send_axes(16'sd0, 16'sd0);
    send_axes(16'sd16384, -16'sd16384);
    send_axes(-16'sd16384, 16'sd16384);
    send_axes(16'sd1638, -16'sd1638);
    send_axes(16'sd1639, -16'sd1639);
    send_axes(16'sd32767, -16'sd32768);
    send_axes(-16'sd32768, 16'sd32767);
    send_axes(-16'sd32768, 16'sd32767);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    cfg_write(REG_DEAD_ZONE, 15'd0);
    cfg_write(REG_FRICTION_OFFSET, 15'd0);
    cfg_write(REG_SPEED_GAIN, 15'h7fff);
    cfg_write(REG_MAX_STEP, 15'h7fff);
    send_axes(16'sd32767, -16'sd32768);
    send_axes(16'sd0, 16'sd0);
    send_axes(-16'sd1, 16'sd1);
    wait_drained();
    // zero gain pulls both targets to 0
    cfg_write(REG_SPEED_GAIN, 15'd0);
    send_axes(16'sd12000, -16'sd12000);
    wait_drained();
    // zero max step freezes any nonzero step
    cfg_write(REG_SPEED_GAIN, 15'(ONE_Q));
    cfg_write(REG_MAX_STEP, 15'd0);
    send_axes(16'sd16384, 16'sd0);
    send_axes(16'sd0, 16'sd0);
    wait_drained();
    cfg_write(REG_DEAD_ZONE, 15'h7fff);
    cfg_write(REG_FRICTION_OFFSET, 15'h7fff);
    cfg_write(REG_MAX_STEP, 15'd1);
    send_axes(16'sd32767, -16'sd32767);
    send_axes(-16'sd32768, 16'sd100);
    wait_drained();
    // indexes beyond the register set must leave everything alone
    cfg_write(4'd4, 15'h7fff);
    cfg_write(4'd15, 15'd0);
    cfg_write(REG_DEAD_ZONE, 15'd100);
    cfg_write(REG_FRICTION_OFFSET, 15'd200);
    cfg_write(REG_MAX_STEP, 15'd16384);
    send_axes(16'sd101, -16'sd5000);
    send_axes(-16'sd100, 16'sd100);
    wait_drained();
  endtask

  task automatic test_input_backpressure();
    idle_on   = 1'b0;
    hold_left = 400;
    for (int i = 0; i < 12; i++)
      send_axes(AXIS_WIDTH'($urandom_range(0, 65535)), AXIS_WIDTH'($urandom_range(0, 65535)));
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic signed [AXIS_WIDTH-1:0] mv, rt;
    logic [REG_WIDTH-1:0]         v;
    int                           k;
    mv = '0;
    rt = '0;
    for (int ph = 0; ph < 11; ph++) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0:       v = 15'd0;
        1:       v = 15'h7fff;
        default: v = REG_WIDTH'($urandom_range(0, 16384));
      endcase
      cfg_write(REG_DEAD_ZONE, v);
      case ($urandom_range(0, 3))
        0:       v = 15'd0;
        1:       v = 15'h7fff;
        default: v = REG_WIDTH'($urandom_range(0, 16384));
      endcase
      cfg_write(REG_FRICTION_OFFSET, v);
      case ($urandom_range(0, 5))
        0:       v = 15'd1;
        1:       v = 15'h7fff;
        2:       v = 15'd0;
        default: v = REG_WIDTH'($urandom_range(1, 32767));
      endcase
      cfg_write(REG_SPEED_GAIN, v);
      case ($urandom_range(0, 9))
        0:       v = 15'd0;
        1:       v = 15'd1;
        2:       v = 15'd16384;
        3:       v = 15'h7fff;
        4, 5, 6: v = REG_WIDTH'($urandom_range(1, 2000));
        default: v = REG_WIDTH'($urandom_range(1, 16384));
      endcase
      cfg_write(REG_MAX_STEP, v);
      if ($urandom_range(0, 3) == 0)
        cfg_write(IDX_WIDTH'($urandom_range(4, 15)), REG_WIDTH'($urandom_range(0, 32767)));
      idle_on = (ph % 3 != 2);
      for (int i = 0; i < 100; i++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            mv = AXIS_WIDTH'($urandom_range(0, 65535));
            rt = AXIS_WIDTH'($urandom_range(0, 65535));
          end
          2, 3, 4: begin
            mv = AXIS_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
            rt = AXIS_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
          end
          5, 6: begin
            k  = int'(dz_r) + $signed($urandom_range(0, 4)) - 2;
            mv = AXIS_WIDTH'($urandom_range(0, 1) ? k : -k);
            k  = int'(dz_r) + $signed($urandom_range(0, 4)) - 2;
            rt = AXIS_WIDTH'($urandom_range(0, 1) ? k : -k);
          end
          default: begin
            mv = AXIS_WIDTH'(mv + $signed($urandom_range(0, 64)) - 32);
            rt = AXIS_WIDTH'(rt + $signed($urandom_range(0, 64)) - 32);
          end
        endcase
        send_axes(mv, rt);
      end
    end
    wait_drained();
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    n_sent       = 0;
    n_recv       = 0;
    n_limited    = 0;
    n_cfg        = 0;
    n_in_stalls  = 0;
    cycle_cnt    = 0;
    idle_on      = 1'b1;
    stall_left   = 0;
    hold_left    = 0;
    dz_r         = 15'((ONE_Q + 5) / 10);
    fo_r         = 15'((2 * ONE_Q + 5) / 10);
    gain_r       = 15'(ONE_Q);
    step_r       = 15'((ONE_Q + 20) / 40);
    prev_drive_q = 0;
    prev_turn_q  = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_default_shaping();
    test_register_extremes();
    test_input_backpressure();
    test_random_phases();

    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    $display("Run covered %0d axis pairs and %0d commands (%0d limited), %0d register writes,",
             n_sent, n_recv, n_limited, n_cfg);
    $display("with %0d cycles of input back-pressure and %0d mismatches.",
             n_in_stalls, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/jsvs_pkg.sv
design/jsvs_front.sv
design/jsvs_queue.sv
design/jsvs_back.sv
design/joystick_shaping_vector_slew.sv
tb/sv/tb_joystick_shaping_vector_slew.sv
